[rtl/core/tprc_pkg.sv]
// tprc_pkg: shared types, constants and helper functions of the text packet route classifier
// no dependencies; imported by tprc_parse, tprc_classify and the core top level
`default_nettype none

package tprc_pkg;

	localparam int ROUTE_ENTRIES = 3;
	localparam int ENTRY_IDX_W   = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int ENTRY_W       = 40;
	localparam int ADDR_W        = 32;
	localparam int LEN_W         = 6;
	localparam int TTL_W         = 16;
	localparam int OCTETS        = 4;
	localparam int CNT_W         = 32;
	localparam int NUM_COUNTERS  = 5;

	localparam int CNT_EXPIRED    = 0;
	localparam int CNT_UNROUTABLE = 1;
	localparam int CNT_DIRECT     = 2;
	localparam int CNT_HOP_B      = 3;
	localparam int CNT_HOP_C      = 4;

	localparam logic [2:0] FIELD_DEST   = 3'd2;
	localparam logic [2:0] FIELD_TTL    = 3'd3;
	localparam logic [2:0] FIELD_ALL    = 3'd4;
	localparam logic [2:0] FIELD_MAX    = 3'd7;
	localparam logic [3:0] DEST_CHR_MAX = 4'd15;
	localparam logic [1:0] DIGITS_MAX   = 2'd3;
	localparam logic [2:0] OCTET_LIMIT  = 3'd4;
	localparam logic [1:0] MATCH_NONE   = 2'd3;
	localparam logic [TTL_W-1:0] TTL_LIVE_MIN = 16'd2;
	localparam logic [LEN_W-1:0] LEN_FULL = 6'd32;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;

	typedef enum logic [2:0] {
		CLS_MALFORMED,
		CLS_EXPIRED,
		CLS_UNROUTABLE,
		CLS_DIRECT,
		CLS_HOP_B,
		CLS_HOP_C,
		CLS_NO_HOP
	} class_t;

	typedef enum logic [1:0] {
		HOP_DIRECT,
		HOP_B,
		HOP_C,
		HOP_NONE
	} hop_t;

	typedef struct packed {
		hop_t              hop;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] addr;
	} route_t;

	typedef struct packed {
		logic [2:0]        field_index;
		logic [TTL_W-1:0]  ttl;
		logic [ADDR_W-1:0] dest;
	} pkt_sum_t;

	typedef struct packed {
		class_t                               cls;
		logic [1:0]                           match;
		logic [ADDR_W-1:0]                    dest;
		logic [NUM_COUNTERS-1:0][CNT_W-1:0]   counts;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_kept(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
			((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_DOT);
	endfunction

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] lc;
		lc = (len > LEN_FULL) ? LEN_FULL : len;
		if (lc == '0) begin
			return '0;
		end
		return {ADDR_W{1'b1}} << (LEN_FULL - lc);
	endfunction

endpackage

`default_nettype wire

[rtl/core/tprc_parse.sv]
// tprc_parse: per-word field parser (commas, ttl decimal, dotted destination)
// depends on tprc_pkg; feeds the packet summary to tprc_classify
`default_nettype none

module tprc_parse (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         char_byte,
	input  wire logic               last_byte,
	output tprc_pkg::pkt_sum_t      pkt
);
	import tprc_pkg::*;

	logic [2:0]              field_q, field_d;
	logic                    first_q, first_d;
	logic [TTL_W-1:0]        ttl_q, ttl_d;
	logic                    ttl_stop_q, ttl_stop_d;
	logic [OCTETS-1:0][7:0]  oct_q, oct_d;
	logic [2:0]              oct_idx_q, oct_idx_d;
	logic [1:0]              dig_q, dig_d;
	logic [3:0]              dchr_q, dchr_d;
	logic [3:0]              digit;
	logic [19:0]             ttl_wide;
	logic [1:0]              oct_sel;

	always_comb begin
		digit    = 4'(char_byte - CH_ZERO);
		ttl_wide = 20'(ttl_q) * 20'd10 + 20'(digit);
		oct_sel  = oct_idx_q[1:0];

		field_d    = field_q;
		first_d    = first_q;
		ttl_d      = ttl_q;
		ttl_stop_d = ttl_stop_q;
		oct_d      = oct_q;
		oct_idx_d  = oct_idx_q;
		dig_d      = dig_q;
		dchr_d     = dchr_q;

		if (first_q) begin
			first_d = 1'b0;
		end else if (char_byte == CH_COMMA) begin
			if (field_q < FIELD_MAX) begin
				field_d = field_q + 3'd1;
			end
		end else if (is_kept(char_byte)) begin
			if (field_q == FIELD_TTL && !ttl_stop_q) begin
				if (is_digit(char_byte)) begin
					ttl_d = (ttl_wide > 20'hFFFF) ? {TTL_W{1'b1}} : ttl_wide[TTL_W-1:0];
				end else begin
					ttl_stop_d = 1'b1;
				end
			end else if (field_q == FIELD_DEST && dchr_q < DEST_CHR_MAX) begin
				dchr_d = dchr_q + 4'd1;
				if (char_byte == CH_DOT) begin
					if (oct_idx_q < OCTET_LIMIT) begin
						oct_idx_d = oct_idx_q + 3'd1;
					end
					dig_d = '0;
				end else if (is_digit(char_byte) && oct_idx_q < OCTET_LIMIT &&
					dig_q < DIGITS_MAX) begin
					oct_d[oct_sel] = 8'(oct_q[oct_sel] * 8'd10 + 8'(digit));
					dig_d          = dig_q + 2'd1;
				end
			end
		end

		pkt.field_index = field_d;
		pkt.ttl         = ttl_d;
		pkt.dest        = {oct_d[0], oct_d[1], oct_d[2], oct_d[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= '0;
			first_q    <= 1'b1;
			ttl_q      <= '0;
			ttl_stop_q <= 1'b0;
			oct_q      <= '0;
			oct_idx_q  <= '0;
			dig_q      <= '0;
			dchr_q     <= '0;
		end else if (step && last_byte) begin
			field_q    <= '0;
			first_q    <= 1'b1;
			ttl_q      <= '0;
			ttl_stop_q <= 1'b0;
			oct_q      <= '0;
			oct_idx_q  <= '0;
			dig_q      <= '0;
			dchr_q     <= '0;
		end else if (step) begin
			field_q    <= field_d;
			first_q    <= first_d;
			ttl_q      <= ttl_d;
			ttl_stop_q <= ttl_stop_d;
			oct_q      <= oct_d;
			oct_idx_q  <= oct_idx_d;
			dig_q      <= dig_d;
			dchr_q     <= dchr_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/tprc_classify.sv]
// tprc_classify: route table, first-match prefix lookup, statistics counters, result register
// depends on tprc_pkg; takes the packet summary from tprc_parse
`default_nettype none

module tprc_classify (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tprc_pkg::ENTRY_IDX_W-1:0]    cfg_index,
	input  wire logic [tprc_pkg::ENTRY_W-1:0]        cfg_data,
	input  wire logic                                load,
	input  tprc_pkg::pkt_sum_t                       pkt,
	output tprc_pkg::result_t                        res
);
	import tprc_pkg::*;

	route_t                             table_q [ROUTE_ENTRIES];
	logic [NUM_COUNTERS-1:0][CNT_W-1:0] cnt_q, cnt_d;
	logic [NUM_COUNTERS-1:0]            bump;
	logic [ROUTE_ENTRIES-1:0]           hit;
	logic                               found;
	logic [ENTRY_IDX_W-1:0]             idx;
	class_t                             cls;
	logic [1:0]                         match;
	result_t                            res_q;

	always_comb begin
		for (int i = 0; i < ROUTE_ENTRIES; i++) begin
			hit[i] = (pkt.dest & prefix_mask(table_q[i].len)) == table_q[i].addr;
		end
		found = 1'b0;
		idx   = '0;
		for (int i = ROUTE_ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found = 1'b1;
				idx   = ENTRY_IDX_W'(i);
			end
		end

		bump  = '0;
		match = MATCH_NONE;
		if (pkt.field_index != FIELD_ALL) begin
			cls = CLS_MALFORMED;
		end else if (pkt.ttl < TTL_LIVE_MIN) begin
			cls               = CLS_EXPIRED;
			bump[CNT_EXPIRED] = 1'b1;
		end else if (found) begin
			match = (32'(idx) < 32'(MATCH_NONE)) ? 2'(idx) : MATCH_NONE;
			case (table_q[idx].hop)
				HOP_DIRECT: begin
					cls              = CLS_DIRECT;
					bump[CNT_DIRECT] = 1'b1;
				end
				HOP_B: begin
					cls             = CLS_HOP_B;
					bump[CNT_HOP_B] = 1'b1;
				end
				HOP_C: begin
					cls             = CLS_HOP_C;
					bump[CNT_HOP_C] = 1'b1;
				end
				default: begin
					cls = CLS_NO_HOP;
				end
			endcase
		end else begin
			cls                  = CLS_UNROUTABLE;
			bump[CNT_UNROUTABLE] = 1'b1;
		end

		for (int k = 0; k < NUM_COUNTERS; k++) begin
			cnt_d[k] = (bump[k] && cnt_q[k] != {CNT_W{1'b1}}) ? cnt_q[k] + 32'd1 : cnt_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROUTE_ENTRIES; i++) begin
				table_q[i] <= '0;
			end
		end else if (cfg_we && 32'(cfg_index) < ROUTE_ENTRIES) begin
			table_q[cfg_index] <= route_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_d;
		end
	end

	// result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (load) begin
			res_q.cls    <= cls;
			res_q.match  <= match;
			res_q.dest   <= pkt.dest;
			res_q.counts <= cnt_d;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

[rtl/core/text_packet_route_classifier_core.sv]
// text_packet_route_classifier_core: top level, input word register and result handshake
// depends on tprc_pkg, tprc_parse and tprc_classify
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, char_byte, last_byte   into block
//   out       out_valid/out_ready, packet_class,        out of block
//             match_entry, dest_address, *_count
//   cfg       cfg_we, cfg_index, cfg_data               into block, write only
//
// one word per cycle unless held; an accepted word is parsed in the cycle that follows
// a word marked last has its result in the output register at the next edge
// the input register only holds when a last word waits on a full, stalled output register
// reset clears the route table, the counters and the parser state
`default_nettype none

module text_packet_route_classifier_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          char_byte,
	input  wire logic                                last_byte,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [2:0]                               packet_class,
	output logic [1:0]                               match_entry,
	output logic [31:0]                              dest_address,
	output logic [31:0]                              expired_count,
	output logic [31:0]                              unroutable_count,
	output logic [31:0]                              direct_count,
	output logic [31:0]                              hop_b_count,
	output logic [31:0]                              hop_c_count,
	input  wire logic                                cfg_we,
	input  wire logic [tprc_pkg::ENTRY_IDX_W-1:0]    cfg_index,
	input  wire logic [tprc_pkg::ENTRY_W-1:0]        cfg_data
);
	import tprc_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       advance;
	logic       step;
	logic       load;
	pkt_sum_t   pkt;
	result_t    res;

	assign advance  = !last_s1 || !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign load     = step && last_s1;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	tprc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_byte (char_s1),
		.last_byte (last_s1),
		.pkt       (pkt)
	);

	tprc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load      (load),
		.pkt       (pkt),
		.res       (res)
	);

	assign out_valid        = out_valid_q;
	assign packet_class     = res.cls;
	assign match_entry      = res.match;
	assign dest_address     = res.dest;
	assign expired_count    = res.counts[CNT_EXPIRED];
	assign unroutable_count = res.counts[CNT_UNROUTABLE];
	assign direct_count     = res.counts[CNT_DIRECT];
	assign hop_b_count      = res.counts[CNT_HOP_B];
	assign hop_c_count      = res.counts[CNT_HOP_C];

`ifndef SYNTHESIS
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result load did not raise out_valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !load)
		else $error("pending result overwritten");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input register not ready");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(load) |-> $stable(res.counts))
		else $error("counters changed without a result");
`endif

endmodule

`default_nettype wire
